FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the estimator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BPE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define BPE_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hdl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants, codes and control types of the battery percent estimator.
// ----------------------------------------------------------------------------
package bpe_pkg;

	localparam int ST_W    = 3;
	localparam int VOLT_W  = 20;
	localparam int PCT_W   = 7;
	localparam int CNT_W   = 5;
	localparam int NOM_W   = 13;
	localparam int DVD_W   = 27;   // pack voltage times 100
	localparam int DVS_W   = 18;   // cell count times nominal mV
	localparam int STEP_W  = 5;
	localparam int DIV_STEPS = DVD_W;
	localparam int PROD_W  = 21;
	localparam int FRAC_W  = 14;

	localparam logic [ST_W-1:0] CS_FAULT   = 3'd0;
	localparam logic [ST_W-1:0] CS_CHG_CC  = 3'd1;
	localparam logic [ST_W-1:0] CS_CHG_CV  = 3'd2;
	localparam logic [ST_W-1:0] CS_CHARGED = 3'd3;
	localparam logic [ST_W-1:0] CS_DISCH   = 3'd4;

	localparam logic [VOLT_W-1:0] CHG_OFFSET = 20'd3250;
	localparam logic [DVD_W-1:0]  LEVEL_ZERO = 27'd860;
	localparam logic [DVD_W-1:0]  LEVEL_FULL = 27'd1000;
	localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
	localparam logic [DVD_W-1:0]  SCALE_100  = 27'd100;
	// (x * 100 / 140) == (x * 11705) >> 14 for x below 140
	localparam logic [13:0]       RECIP_5_7  = 14'd11705;

	localparam logic [CNT_W-1:0]  CELL_COUNT_RST  = 5'd3;
	localparam logic [NOM_W-1:0]  CELL_NOMINAL_RST = 13'd3700;

	localparam logic REG_CELL_COUNT   = 1'b0;
	localparam logic REG_CELL_NOMINAL = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic mul;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/bpe_if.sv
// ----------------------------------------------------------------------------
// bpe_if
// Sample and result channels of the battery percent estimator.
// ----------------------------------------------------------------------------
interface bpe_in_if;
	logic                        valid;
	logic                        ready;
	logic [bpe_pkg::ST_W-1:0]    charge_state;
	logic [bpe_pkg::VOLT_W-1:0]  pack_voltage;

	modport source(output valid, charge_state, pack_voltage, input ready);
	modport sink(input valid, charge_state, pack_voltage, output ready);
endinterface

interface bpe_out_if;
	logic                        valid;
	logic                        ready;
	logic [bpe_pkg::PCT_W-1:0]   percent;

	modport source(output valid, percent, input ready);
	modport sink(input valid, percent, output ready);
endinterface

FILE: hdl/bpe_ctrl.sv
// ----------------------------------------------------------------------------
// bpe_ctrl
// Sequencer: accept, divide, scale, commit into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bpe_pkg::sts_t sts,
	output bpe_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`BPE_ASSERT_NEXT(a_div_holds, state_q == ST_DIV && !sts.div_done, state_q == ST_DIV, "divider left early")
	`BPE_ASSERT_NEXT(a_done_waits, state_q == ST_DONE && !sts.out_free, state_q == ST_DONE && !in_ready, "result dropped while output busy")

endmodule

FILE: hdl/bpe_dp.sv
// ----------------------------------------------------------------------------
// bpe_dp
// Datapath: offset, restoring divider, linear scale, hold rule, output reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpe_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpe_pkg::cmd_t                 cmd,
	output bpe_pkg::sts_t                 sts,
	input  logic [bpe_pkg::ST_W-1:0]      charge_state,
	input  logic [bpe_pkg::VOLT_W-1:0]    pack_voltage,
	input  logic [bpe_pkg::CNT_W-1:0]     cell_count,
	input  logic [bpe_pkg::NOM_W-1:0]     cell_nominal_mv,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bpe_pkg::PCT_W-1:0]     percent
);

	logic [bpe_pkg::ST_W-1:0]   st_q;
	logic [bpe_pkg::DVS_W-1:0]  divisor_q;
	logic                       zero_q;
	logic [bpe_pkg::DVS_W-1:0]  rem_q;
	logic [bpe_pkg::DVD_W-1:0]  quo_q;
	logic [bpe_pkg::STEP_W-1:0] cnt_q;
	logic [bpe_pkg::PROD_W-1:0] prod_q;
	logic [bpe_pkg::PCT_W-1:0]  held_q;
	logic                       first_q;
	logic [bpe_pkg::PCT_W-1:0]  last_q;
	logic                       out_valid_q;

	logic                       charging_in;
	logic [bpe_pkg::VOLT_W-1:0] v_adj;
	logic [bpe_pkg::DVS_W:0]    shifted;
	logic                       ge;
	logic [bpe_pkg::DVS_W:0]    diff;
	logic [bpe_pkg::DVD_W-1:0]  level;
	logic [7:0]                 excess;
	logic                       charging;
	logic                       low;
	logic [bpe_pkg::PCT_W-1:0]  p;
	logic [bpe_pkg::PCT_W-1:0]  res;
	logic [bpe_pkg::PCT_W-1:0]  held_d;
	logic                       first_d;

	assign charging_in = (charge_state == bpe_pkg::CS_CHG_CC) ||
		(charge_state == bpe_pkg::CS_CHG_CV);

	always_comb begin
		v_adj = pack_voltage;
		if (charging_in) begin
			v_adj = (pack_voltage > bpe_pkg::CHG_OFFSET) ?
				pack_voltage - bpe_pkg::CHG_OFFSET : '0;
		end
	end

	// one quotient bit per cycle
	assign shifted = {rem_q, quo_q[bpe_pkg::DVD_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	assign level  = zero_q ? '0 : quo_q;
	assign excess = 8'(level - bpe_pkg::LEVEL_ZERO);

	assign charging = (st_q == bpe_pkg::CS_CHG_CC) || (st_q == bpe_pkg::CS_CHG_CV);
	assign low      = level <= bpe_pkg::LEVEL_ZERO;
	assign p        = (level >= bpe_pkg::LEVEL_FULL) ? bpe_pkg::PCT_FULL :
		prod_q[bpe_pkg::PROD_W-1:bpe_pkg::FRAC_W];

	always_comb begin
		res     = last_q;
		held_d  = held_q;
		first_d = first_q;
		unique case (st_q) inside
			bpe_pkg::CS_FAULT: begin
				res     = '0;
				held_d  = '0;
				first_d = 1'b1;
			end
			bpe_pkg::CS_CHG_CC, bpe_pkg::CS_CHG_CV, bpe_pkg::CS_DISCH: begin
				if (low) begin
					res     = '0;
					held_d  = '0;
					first_d = 1'b1;
				end else if (first_q) begin
					first_d = 1'b0;
					held_d  = p;
					res     = p;
				end else if (charging ? (p < held_q) : (p > held_q)) begin
					res = held_q;
				end else begin
					held_d = p;
					res    = p;
				end
			end
			bpe_pkg::CS_CHARGED: begin
				res    = bpe_pkg::PCT_FULL;
				held_d = bpe_pkg::PCT_FULL;
			end
			default: begin
			end
		endcase
	end

	assign sts.div_done = cnt_q == bpe_pkg::STEP_W'(bpe_pkg::DIV_STEPS - 1);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			st_q      <= charge_state;
			divisor_q <= bpe_pkg::DVS_W'(cell_count) * bpe_pkg::DVS_W'(cell_nominal_mv);
			zero_q    <= (cell_count == '0) || (cell_nominal_mv == '0);
			rem_q     <= '0;
			quo_q     <= bpe_pkg::DVD_W'(v_adj) * bpe_pkg::SCALE_100;
		end else if (cmd.step) begin
			rem_q <= ge ? diff[bpe_pkg::DVS_W-1:0] : shifted[bpe_pkg::DVS_W-1:0];
			quo_q <= {quo_q[bpe_pkg::DVD_W-2:0], ge};
		end
		if (cmd.mul) begin
			prod_q <= bpe_pkg::PROD_W'(excess) * bpe_pkg::PROD_W'(bpe_pkg::RECIP_5_7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			held_q      <= bpe_pkg::PCT_FULL;
			first_q     <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				held_q      <= held_d;
				first_q     <= first_d;
				last_q      <= res;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign percent   = last_q;

	`BPE_ASSERT(a_held_range, held_q <= bpe_pkg::PCT_FULL, "held percent above full")
	`BPE_ASSERT(a_out_range, !out_valid_q || last_q <= bpe_pkg::PCT_FULL, "percent above full")
	`BPE_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_q, "committed word not presented")

endmodule

FILE: hdl/battery_percent_estimator.sv
// ----------------------------------------------------------------------------
// battery_percent_estimator
// Battery charge percentage from charger state and pack voltage.
//
//   channel  dir  handshake       payload
//   sample   in   valid/ready     charge_state[2:0], pack_voltage[19:0]
//   result   out  valid/ready     percent[6:0]
//   apb      in   psel/penable    cell_count @0x0, cell_nominal_mv @0x4
//
// One word in flight; the next sample is taken only after the last one is
// committed: the accept, the one-bit-per-cycle restoring divider, one
// scale multiply and one commit into the output register.
// A finished word waits in the output register; a new sample is accepted
// meanwhile, and its commit stalls only while the old word is untaken.
// arst_n resets control, held percent (to 100), the output word and the cell registers (3 cells, 3700 mV).
// ----------------------------------------------------------------------------
module battery_percent_estimator (
	input  logic              clk,
	input  logic              arst_n,
	bpe_in_if.sink            sample,
	bpe_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [bpe_pkg::CNT_W-1:0] cell_count_q;
	logic [bpe_pkg::NOM_W-1:0] cell_nominal_q;
	bpe_pkg::cmd_t             cmd;
	bpe_pkg::sts_t             sts;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q   <= bpe_pkg::CELL_COUNT_RST;
			cell_nominal_q <= bpe_pkg::CELL_NOMINAL_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				bpe_pkg::REG_CELL_COUNT:   cell_count_q   <= pwdata[bpe_pkg::CNT_W-1:0];
				bpe_pkg::REG_CELL_NOMINAL: cell_nominal_q <= pwdata[bpe_pkg::NOM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			bpe_pkg::REG_CELL_COUNT:   prdata = 32'(cell_count_q);
			bpe_pkg::REG_CELL_NOMINAL: prdata = 32'(cell_nominal_q);
			default:                   prdata = '0;
		endcase
	end

	bpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.charge_state    (sample.charge_state),
		.pack_voltage    (sample.pack_voltage),
		.cell_count      (cell_count_q),
		.cell_nominal_mv (cell_nominal_q),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.percent         (result.percent)
	);

endmodule

FILE: verif/bpe_percent_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpe_percent_checker
// Watches the sample, result and APB ports of the estimator, keeps its own
// copy of the register settings and held-percent state, predicts the percent
// of every accepted sample word and compares it with the result words in
// order.
// ----------------------------------------------------------------------------
module bpe_percent_checker (
	input  logic        clk,
	input  logic        arst_n,
	bpe_in_if           sample,
	bpe_out_if          result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);

	localparam longint unsigned ZERO_LEVEL = 64'(bpe_pkg::LEVEL_ZERO);
	localparam longint unsigned SPAN_LEVEL = 64'(bpe_pkg::LEVEL_FULL - bpe_pkg::LEVEL_ZERO);
	localparam longint unsigned HUNDRED    = 64'(bpe_pkg::SCALE_100);
	localparam longint unsigned FULL_PCT   = 64'(bpe_pkg::PCT_FULL);
	localparam longint unsigned OFFSET     = 64'(bpe_pkg::CHG_OFFSET);

	logic [bpe_pkg::CNT_W-1:0] cell_cnt;
	logic [bpe_pkg::NOM_W-1:0] cell_nom;
	logic [bpe_pkg::PCT_W-1:0] held_pct;
	logic [bpe_pkg::PCT_W-1:0] last_pct;
	bit                        rearmed;
	logic [bpe_pkg::PCT_W-1:0] percent_due[$];

	initial fail_count = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic logic [bpe_pkg::PCT_W-1:0] predict_percent(
			input logic [bpe_pkg::ST_W-1:0] st,
			input logic [bpe_pkg::VOLT_W-1:0] volt);
		longint unsigned v;
		longint unsigned div;
		longint unsigned level;
		longint unsigned p;
		bit charging;
		charging = (st == bpe_pkg::CS_CHG_CC) || (st == bpe_pkg::CS_CHG_CV);
		v = 64'(volt);
		div = 64'(cell_cnt);
		div = div * 64'(cell_nom);
		case (st) inside
			bpe_pkg::CS_FAULT: begin
				last_pct = '0;
				held_pct = '0;
				rearmed = 1'b1;
			end
			bpe_pkg::CS_CHARGED: begin
				last_pct = bpe_pkg::PCT_FULL;
				held_pct = bpe_pkg::PCT_FULL;
			end
			bpe_pkg::CS_CHG_CC, bpe_pkg::CS_CHG_CV, bpe_pkg::CS_DISCH: begin
				if (charging)
					v = (v > OFFSET) ? v - OFFSET : 64'd0;
				level = (div == 0) ? 64'd0 : (v * HUNDRED) / div;
				if (level <= ZERO_LEVEL) begin
					held_pct = '0;
					rearmed = 1'b1;
					last_pct = '0;
				end else begin
					p = ((level - ZERO_LEVEL) * HUNDRED) / SPAN_LEVEL;
					if (p > FULL_PCT)
						p = FULL_PCT;
					if (rearmed) begin
						rearmed = 1'b0;
						held_pct = p[bpe_pkg::PCT_W-1:0];
					end else if (charging ? (p < 64'(held_pct)) : (p > 64'(held_pct))) begin
						p = 64'(held_pct);
					end else begin
						held_pct = p[bpe_pkg::PCT_W-1:0];
					end
					last_pct = p[bpe_pkg::PCT_W-1:0];
				end
			end
			default: begin
				// unknown state: nothing moves, last word repeats
			end
		endcase
		return last_pct;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [bpe_pkg::PCT_W-1:0] want;
		if (!arst_n) begin
			cell_cnt = bpe_pkg::CELL_COUNT_RST;
			cell_nom = bpe_pkg::CELL_NOMINAL_RST;
			held_pct = bpe_pkg::PCT_FULL;
			last_pct = '0;
			rearmed = 1'b0;
			percent_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == bpe_pkg::REG_CELL_COUNT)
					cell_cnt = pwdata[bpe_pkg::CNT_W-1:0];
				else
					cell_nom = pwdata[bpe_pkg::NOM_W-1:0];
			end
			if (result.valid && result.ready) begin
				if (percent_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result word, percent %0d",
						result.percent));
				end else begin
					want = percent_due.pop_front();
					if (result.percent !== want)
						report_mismatch($sformatf("percent mismatch: got %0d expected %0d",
							result.percent, want));
				end
			end
			if (sample.valid && sample.ready)
				percent_due.push_back(predict_percent(sample.charge_state,
					sample.pack_voltage));
			pending <= percent_due.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the battery percent estimator: a short directed sequence at
// the reset settings, then phases of random charge/discharge runs under
// several register settings, with random idling on both channels and one
// long result stall. The checker predicts and compares; this module drives
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD   = 4;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 64;
	localparam int NUM_PHASES   = 8;
	localparam logic [bpe_pkg::ST_W-1:0]   CS_UNKNOWN_LO = bpe_pkg::CS_DISCH + 3'd1;
	localparam logic [bpe_pkg::ST_W-1:0]   CS_UNKNOWN_HI = 3'd7;
	localparam logic [bpe_pkg::VOLT_W-1:0] VOLT_MAX      = '1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int cycles = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_left = 0;

	logic [bpe_pkg::CNT_W-1:0] cfg_cnt = bpe_pkg::CELL_COUNT_RST;
	logic [bpe_pkg::NOM_W-1:0] cfg_nom = bpe_pkg::CELL_NOMINAL_RST;
	int drift_level = 930;
	bit charging_run = 1'b0;

	bpe_in_if  sample_ch();
	bpe_out_if result_ch();

	battery_percent_estimator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bpe_percent_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.result     (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stall bursts plus one long hold on request
	always @(negedge clk) begin
		logic rdy;
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = int'($urandom_range(1, 8)) - 1;
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
		end
		result_ch.ready <= rdy;
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic set_config(input int cc, input int nom);
		cfg_cnt = cc[bpe_pkg::CNT_W-1:0];
		cfg_nom = nom[bpe_pkg::NOM_W-1:0];
		apb_write({bpe_pkg::REG_CELL_COUNT, 2'b00}, 32'(cfg_cnt));
		apb_write({bpe_pkg::REG_CELL_NOMINAL, 2'b00}, 32'(cfg_nom));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_sample(input logic [bpe_pkg::ST_W-1:0] st,
			input logic [bpe_pkg::VOLT_W-1:0] v);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) : 0;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.charge_state <= st;
		sample_ch.pack_voltage <= v;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// voltage that lands on a given per-mille level under the current settings
	function automatic logic [bpe_pkg::VOLT_W-1:0] volt_for(input int level,
			input bit charging);
		longint unsigned div;
		longint unsigned v;
		div = 64'(cfg_cnt);
		div = div * 64'(cfg_nom);
		if (div == 0)
			v = 64'($urandom_range(0, VOLT_MAX));
		else
			v = (64'(level) * div + 64'd99) / 64'd100;
		if (charging)
			v += 64'(bpe_pkg::CHG_OFFSET);
		if (v > 64'(VOLT_MAX))
			v = 64'(VOLT_MAX);
		return v[bpe_pkg::VOLT_W-1:0];
	endfunction

	task automatic gen_item(output logic [bpe_pkg::ST_W-1:0] st,
			output logic [bpe_pkg::VOLT_W-1:0] v);
		int r;
		int target;
		r = int'($urandom_range(0, 99));
		if ($urandom_range(0, 14) == 0)
			charging_run = !charging_run;
		drift_level += int'($urandom_range(0, 30)) - 15;
		if (drift_level < 780)
			drift_level = 780;
		if (drift_level > 1080)
			drift_level = 1080;
		v = bpe_pkg::VOLT_W'($urandom_range(0, VOLT_MAX));
		if (r < 4) begin
			st = bpe_pkg::CS_FAULT;
		end else if (r < 10) begin
			st = bpe_pkg::CS_CHARGED;
		end else if (r < 14) begin
			st = bpe_pkg::ST_W'($urandom_range(CS_UNKNOWN_LO, CS_UNKNOWN_HI));
		end else if (r < 22) begin
			st = bpe_pkg::ST_W'($urandom_range(0, CS_UNKNOWN_HI));
		end else begin
			if (charging_run)
				st = $urandom_range(0, 1) ? bpe_pkg::CS_CHG_CC : bpe_pkg::CS_CHG_CV;
			else
				st = bpe_pkg::CS_DISCH;
			target = drift_level + int'($urandom_range(0, 8)) - 4;
			v = volt_for(target, charging_run);
		end
	endtask

	initial begin
		int cnt_tab[NUM_PHASES] = '{1, 16, 31, 0, 3, 1, 12, 3};
		int nom_tab[NUM_PHASES] = '{1, 5000, 8191, 3700, 0, 5000, 3300, 3700};
		int len_tab[NUM_PHASES] = '{120, 140, 120, 30, 30, 140, 140, 250};
		logic [bpe_pkg::ST_W-1:0]   st;
		logic [bpe_pkg::VOLT_W-1:0] v;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.charge_state = bpe_pkg::CS_FAULT;
		sample_ch.pack_voltage = '0;
		result_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words at reset settings
		push_sample(bpe_pkg::CS_DISCH, '0);
		push_sample(bpe_pkg::CS_DISCH, VOLT_MAX);
		push_sample(bpe_pkg::CS_DISCH, volt_for(950, 1'b0));
		push_sample(bpe_pkg::CS_DISCH, volt_for(980, 1'b0));
		push_sample(bpe_pkg::CS_DISCH, volt_for(1000, 1'b0));
		push_sample(bpe_pkg::CS_DISCH, volt_for(861, 1'b0));
		push_sample(bpe_pkg::CS_DISCH, volt_for(860, 1'b0));
		push_sample(bpe_pkg::CS_CHG_CC, 20'd100);
		push_sample(bpe_pkg::CS_CHG_CC, bpe_pkg::CHG_OFFSET);
		push_sample(bpe_pkg::CS_CHG_CV, volt_for(900, 1'b1));
		push_sample(bpe_pkg::CS_CHG_CC, volt_for(880, 1'b1));
		push_sample(bpe_pkg::CS_CHG_CV, volt_for(990, 1'b1));
		push_sample(bpe_pkg::CS_CHG_CC, VOLT_MAX);
		push_sample(bpe_pkg::CS_CHARGED, '0);
		push_sample(bpe_pkg::CS_CHARGED, VOLT_MAX);
		for (int s = CS_UNKNOWN_LO; s <= CS_UNKNOWN_HI; s++)
			push_sample(s[bpe_pkg::ST_W-1:0],
				bpe_pkg::VOLT_W'($urandom_range(0, VOLT_MAX)));
		push_sample(bpe_pkg::CS_FAULT, VOLT_MAX);
		push_sample(bpe_pkg::CS_DISCH, volt_for(1000, 1'b0));
		push_sample(bpe_pkg::CS_CHG_CV, volt_for(870, 1'b1));
		push_sample(CS_UNKNOWN_LO, '0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			if (ph == 6)
				set_config(int'($urandom_range(1, 16)), int'($urandom_range(1, 5000)));
			else
				set_config(cnt_tab[ph], nom_tab[ph]);
			if (ph == NUM_PHASES - 1)
				idle_on = 1'b0;
			for (int i = 0; i < len_tab[ph]; i++) begin
				if (ph == 1 && i == 20)
					hold_req = 1'b1;
				gen_item(st, v);
				push_sample(st, v);
			end
		end

		sample_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: battery_percent_estimator.f
+incdir+hdl
hdl/bpe_pkg.sv
hdl/bpe_if.sv
hdl/bpe_ctrl.sv
hdl/bpe_dp.sv
hdl/battery_percent_estimator.sv
verif/bpe_percent_checker.sv
verif/tb_top.sv
